/* hdl/bsicm_pkg.sv */
// Shared types, address codes and helpers for the bank switch interrupt counter mapper.
`default_nettype none
package bsicm_pkg;

  // Item kinds
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // Address regions, taken from address bits 15..12
  localparam logic [3:0] REGION_PRG0 = 4'h8;
  localparam logic [3:0] REGION_CTRL = 4'h9;
  localparam logic [3:0] REGION_PRG1 = 4'hA;
  localparam logic [3:0] REGION_CHR  = 4'hB;
  localparam logic [3:0] REGION_PRG2 = 4'hC;

  // Control register codes within the control region, address bits 2..0
  localparam logic [2:0] CTRL_MIRROR  = 3'd1;
  localparam logic [2:0] CTRL_ENABLE  = 3'd3;
  localparam logic [2:0] CTRL_RELOAD  = 3'd4;
  localparam logic [2:0] CTRL_LOAD_HI = 3'd5;
  localparam logic [2:0] CTRL_LOAD_LO = 3'd6;

  // Configuration register indexes
  localparam logic REG_PRG_MAX = 1'b0;
  localparam logic REG_CHR_MAX = 1'b1;

  localparam int unsigned ADDR_W     = 3;
  localparam logic [7:0]  BANK_MAX_RST = 8'hFF;
  localparam int unsigned PRG_SLOTS  = 3;
  localparam int unsigned CHR_SLOTS  = 8;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } item_t;

  typedef struct packed {
    logic [7:0] prg_max;
    logic [7:0] chr_max;
  } limits_t;

  typedef struct packed {
    logic       irq_out;
    logic       mirror_horizontal_out;
    logic [7:0] prg_bank_first;
    logic [7:0] prg_bank_second;
    logic [7:0] prg_bank_third;
    logic       chr_write_valid;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
  } result_t;

  // Fold an out-of-range bank to within the maximum by masking it with the maximum
  function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] max);
    return (v > max) ? (v & max) : v;
  endfunction

endpackage
`default_nettype wire

/* hdl/bsicm_cfg.sv */
// APB-style register file holding the two bank limits.
`default_nettype none
module bsicm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsicm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output bsicm_pkg::limits_t                 limits
);
  import bsicm_pkg::*;

  logic [7:0] prg_max_r;
  logic [7:0] chr_max_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_max_r <= BANK_MAX_RST;
      chr_max_r <= BANK_MAX_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_PRG_MAX) begin
        prg_max_r <= pwdata[7:0];
      end else begin
        chr_max_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_PRG_MAX) begin
      prdata[7:0] = prg_max_r;
    end else begin
      prdata[7:0] = chr_max_r;
    end
  end

  assign limits.prg_max = prg_max_r;
  assign limits.chr_max = chr_max_r;

endmodule
`default_nettype wire

/* hdl/bsicm_core.sv */
// Mapper state: bank registers, mirroring, interrupt counter and its update logic.
`default_nettype none
module bsicm_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire bsicm_pkg::item_t   item,
  input  wire bsicm_pkg::limits_t limits,
  output bsicm_pkg::result_t      result
);
  import bsicm_pkg::*;

  logic [7:0]  prg_r   [PRG_SLOTS];
  logic [7:0]  prg_nxt [PRG_SLOTS];
  logic [7:0]  chr_r   [CHR_SLOTS];
  logic [7:0]  chr_nxt [CHR_SLOTS];
  logic        mirror_r, mirror_nxt;
  logic        cnt_en_r, cnt_en_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic        delay_r, delay_nxt;
  logic        irq_r, irq_nxt;

  logic [3:0]  region;
  logic [2:0]  low3;
  logic [7:0]  prg_val;
  logic [7:0]  chr_val;

  assign region  = item.bus_address[15:12];
  assign low3    = item.bus_address[2:0];
  assign prg_val = limit_bank(item.bus_data, limits.prg_max);
  assign chr_val = limit_bank(item.bus_data, limits.chr_max);

  always_comb begin
    prg_nxt    = prg_r;
    chr_nxt    = chr_r;
    mirror_nxt = mirror_r;
    cnt_en_nxt = cnt_en_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    delay_nxt  = delay_r;
    irq_nxt    = irq_r;
    result     = '0;

    if (item.command == CMD_TICK) begin
      // A delay armed on the previous tick raises the line now
      if (delay_r) begin
        delay_nxt = 1'b0;
        irq_nxt   = 1'b1;
      end
      if (cnt_en_r && (cnt_r != 16'd0)) begin
        cnt_nxt = cnt_r - 16'd1;
        if (cnt_r == 16'd1) begin
          cnt_en_nxt = 1'b0;
          delay_nxt  = 1'b1;
        end
      end
    end else begin
      case (region)
        REGION_PRG0: prg_nxt[0] = prg_val;
        REGION_PRG1: prg_nxt[1] = prg_val;
        REGION_PRG2: prg_nxt[2] = prg_val;
        REGION_CHR: begin
          chr_nxt[low3]          = chr_val;
          result.chr_write_valid = 1'b1;
          result.chr_slot        = low3;
          result.chr_bank        = chr_val;
        end
        REGION_CTRL: begin
          case (low3)
            CTRL_MIRROR: mirror_nxt = item.bus_data[7];
            CTRL_ENABLE: begin
              cnt_en_nxt = item.bus_data[7];
              irq_nxt    = 1'b0;
            end
            CTRL_RELOAD: begin
              cnt_nxt = reload_r;
              irq_nxt = 1'b0;
            end
            CTRL_LOAD_HI: reload_nxt = {item.bus_data, reload_r[7:0]};
            CTRL_LOAD_LO: reload_nxt = {reload_r[15:8], item.bus_data};
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    result.irq_out               = irq_nxt;
    result.mirror_horizontal_out = mirror_nxt;
    result.prg_bank_first        = prg_nxt[0];
    result.prg_bank_second       = prg_nxt[1];
    result.prg_bank_third        = prg_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PRG_SLOTS; i++) prg_r[i] <= '0;
      for (int i = 0; i < CHR_SLOTS; i++) chr_r[i] <= '0;
      mirror_r <= 1'b0;
      cnt_en_r <= 1'b0;
      cnt_r    <= '0;
      reload_r <= '0;
      delay_r  <= 1'b0;
      irq_r    <= 1'b0;
    end else if (step_en) begin
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      mirror_r <= mirror_nxt;
      cnt_en_r <= cnt_en_nxt;
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      delay_r  <= delay_nxt;
      irq_r    <= irq_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/bank_switch_irq_counter_mapper_core.sv */
// Top level of the bank switch interrupt counter mapper: input stage, core, result stage.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one beat per item: a CPU bus
//   write (in_command 0, with in_bus_address and in_bus_data) or one CPU cycle
//   tick (in_command 1). Every accepted beat yields exactly one result beat on
//   the output channel (out_valid / out_stall) with the interrupt line, the
//   mirroring, the three program banks and any pattern bank write it caused.
//   An accepted beat is captured in the input register, then processed through
//   the core into the result register, and shows on out_* from there. The block
//   takes one beat per clock while out_stall does not hold the result register;
//   the mapper state updates as each beat advances, so a tick may follow any beat.
//   The input register keeps taking beats while a finished result waits; when
//   the receiver holds out_stall high the result register holds, the input
//   register fills, and then in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) clears all banks, the counter, the reload
//   value and the interrupt, empties both stages and sets both bank limits
//   to 255. The limits are written over the APB port (0x0 program, 0x4 pattern)
//   while the block is idle.
`default_nettype none
module bank_switch_irq_counter_mapper_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [15:0]                   in_bus_address,
  input  wire logic [7:0]                    in_bus_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_irq_out,
  output logic                               out_mirror_horizontal_out,
  output logic [7:0]                         out_prg_bank_first,
  output logic [7:0]                         out_prg_bank_second,
  output logic [7:0]                         out_prg_bank_third,
  output logic                               out_chr_write_valid,
  output logic [2:0]                         out_chr_slot,
  output logic [7:0]                         out_chr_bank,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsicm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import bsicm_pkg::*;

  limits_t limits;
  item_t   s1_item_r;
  logic    s1_valid_r;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;
  logic    s1_load;

  bsicm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // Move the held item through the core when the result register is free
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign s1_load  = ~s1_valid_r | advance;
  assign in_stall = ~s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r <= item_t'({in_command, in_bus_address, in_bus_data});
    end
  end

  bsicm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .limits  (limits),
    .result  (core_res)
  );

  // Result register: drop the beat once taken, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_irq_out               = out_res_r.irq_out;
  assign out_mirror_horizontal_out = out_res_r.mirror_horizontal_out;
  assign out_prg_bank_first        = out_res_r.prg_bank_first;
  assign out_prg_bank_second       = out_res_r.prg_bank_second;
  assign out_prg_bank_third        = out_res_r.prg_bank_third;
  assign out_chr_write_valid       = out_res_r.chr_write_valid;
  assign out_chr_slot              = out_res_r.chr_slot;
  assign out_chr_bank              = out_res_r.chr_bank;

endmodule
`default_nettype wire

/* tb/bsicm_result_checker.sv */
// Result checker for the bank switch interrupt counter mapper: predicts and compares every beat.
module bsicm_result_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_command,
  input  wire logic [15:0]                   in_bus_address,
  input  wire logic [7:0]                    in_bus_data,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_irq_out,
  input  wire logic                          out_mirror_horizontal_out,
  input  wire logic [7:0]                    out_prg_bank_first,
  input  wire logic [7:0]                    out_prg_bank_second,
  input  wire logic [7:0]                    out_prg_bank_third,
  input  wire logic                          out_chr_write_valid,
  input  wire logic [2:0]                    out_chr_slot,
  input  wire logic [7:0]                    out_chr_bank,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsicm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  input  wire logic                          pready,
  output int unsigned                        outstanding,
  output int unsigned                        mismatches
);
  import bsicm_pkg::*;

  logic [7:0]  prg_limit;
  logic [7:0]  chr_limit;
  logic [7:0]  prg_bank [PRG_SLOTS];
  logic [7:0]  chr_bank [CHR_SLOTS];
  logic        mirror_h;
  logic        count_en;
  logic [15:0] down_count;
  logic [15:0] reload;
  logic        irq_armed;
  logic        irq_line;
  result_t     pending_views [$];

  // Mask a bank number only when it lies above the limit
  function automatic logic [7:0] clip_bank(input logic [7:0] v, input logic [7:0] lim);
    return (v > lim) ? (v & lim) : v;
  endfunction

  // Advance the mapper by one item and return the outputs it shows afterwards
  function automatic result_t mapper_view_after(input item_t it);
    result_t    r;
    logic [2:0] slot;
    r = '0;
    slot = it.bus_address[2:0];
    if (it.command == CMD_TICK) begin
      if (irq_armed) begin
        irq_armed = 1'b0;
        irq_line  = 1'b1;
      end
      if (count_en && down_count != 16'd0) begin
        down_count = down_count - 16'd1;
        if (down_count == 16'd0) begin
          count_en  = 1'b0;
          irq_armed = 1'b1;
        end
      end
    end else begin
      case (it.bus_address[15:12])
        REGION_PRG0: prg_bank[0] = clip_bank(it.bus_data, prg_limit);
        REGION_PRG1: prg_bank[1] = clip_bank(it.bus_data, prg_limit);
        REGION_PRG2: prg_bank[2] = clip_bank(it.bus_data, prg_limit);
        REGION_CHR: begin
          chr_bank[slot] = clip_bank(it.bus_data, chr_limit);
          r.chr_write_valid = 1'b1;
          r.chr_slot        = slot;
          r.chr_bank        = chr_bank[slot];
        end
        REGION_CTRL: begin
          case (slot)
            CTRL_MIRROR: mirror_h = it.bus_data[7];
            CTRL_ENABLE: begin
              count_en = it.bus_data[7];
              irq_line = 1'b0;
            end
            CTRL_RELOAD: begin
              down_count = reload;
              irq_line   = 1'b0;
            end
            CTRL_LOAD_HI: reload[15:8] = it.bus_data;
            CTRL_LOAD_LO: reload[7:0]  = it.bus_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.irq_out               = irq_line;
    r.mirror_horizontal_out = mirror_h;
    r.prg_bank_first        = prg_bank[0];
    r.prg_bank_second       = prg_bank[1];
    r.prg_bank_third        = prg_bank[2];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    item_t   it;
    if (!rst_n) begin
      prg_limit  = BANK_MAX_RST;
      chr_limit  = BANK_MAX_RST;
      foreach (prg_bank[i]) prg_bank[i] = 8'h00;
      foreach (chr_bank[i]) chr_bank[i] = 8'h00;
      mirror_h   = 1'b0;
      count_en   = 1'b0;
      down_count = 16'h0000;
      reload     = 16'h0000;
      irq_armed  = 1'b0;
      irq_line   = 1'b0;
      pending_views.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PRG_MAX: prg_limit = pwdata[7:0];
          REG_CHR_MAX: chr_limit = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        it.command     = cmd_t'(in_command);
        it.bus_address = in_bus_address;
        it.bus_data    = in_bus_data;
        pending_views.push_back(mapper_view_after(it));
      end
      if (out_valid && !out_stall) begin
        if (pending_views.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          compare_field("irq_out", 8'(want.irq_out), 8'(out_irq_out));
          compare_field("mirror_horizontal_out", 8'(want.mirror_horizontal_out),
                        8'(out_mirror_horizontal_out));
          compare_field("prg_bank_first", want.prg_bank_first, out_prg_bank_first);
          compare_field("prg_bank_second", want.prg_bank_second, out_prg_bank_second);
          compare_field("prg_bank_third", want.prg_bank_third, out_prg_bank_third);
          compare_field("chr_write_valid", 8'(want.chr_write_valid),
                        8'(out_chr_write_valid));
          compare_field("chr_slot", 8'(want.chr_slot), 8'(out_chr_slot));
          compare_field("chr_bank", want.chr_bank, out_chr_bank);
        end
      end
    end
    outstanding <= pending_views.size();
  end

endmodule

/* tb/bank_switch_irq_counter_mapper_core_tb.sv */
// Testbench top for the bank switch interrupt counter mapper: stimulus, idling and verdict.
module bank_switch_irq_counter_mapper_core_tb;
  import bsicm_pkg::*;

  // Random beats split over six segments, two per idling phase
  localparam int unsigned RANDOM_BEATS = 1650;
  localparam int unsigned SEGMENTS     = 6;
  localparam int unsigned HALF_SEGMENT = RANDOM_BEATS / (2 * SEGMENTS);

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_command     = 1'b0;
  logic [15:0]       in_bus_address = 16'h0000;
  logic [7:0]        in_bus_data    = 8'h00;
  logic              out_stall      = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [31:0]       pwdata         = 32'h0;

  wire logic         in_stall;
  wire logic         out_valid;
  wire logic         out_irq_out;
  wire logic         out_mirror_horizontal_out;
  wire logic [7:0]   out_prg_bank_first;
  wire logic [7:0]   out_prg_bank_second;
  wire logic [7:0]   out_prg_bank_third;
  wire logic         out_chr_write_valid;
  wire logic [2:0]   out_chr_slot;
  wire logic [7:0]   out_chr_bank;
  wire logic [31:0]  prdata;
  wire logic         pready;

  int unsigned       outstanding;
  int unsigned       mismatches;
  int unsigned       beats_sent     = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;

  bank_switch_irq_counter_mapper_core uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_command                (in_command),
    .in_bus_address            (in_bus_address),
    .in_bus_data               (in_bus_data),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_irq_out               (out_irq_out),
    .out_mirror_horizontal_out (out_mirror_horizontal_out),
    .out_prg_bank_first        (out_prg_bank_first),
    .out_prg_bank_second       (out_prg_bank_second),
    .out_prg_bank_third        (out_prg_bank_third),
    .out_chr_write_valid       (out_chr_write_valid),
    .out_chr_slot              (out_chr_slot),
    .out_chr_bank              (out_chr_bank),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .prdata                    (prdata),
    .pready                    (pready)
  );

  // Watch both channels and the register port beside the block
  bsicm_result_checker result_watch (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_command                (in_command),
    .in_bus_address            (in_bus_address),
    .in_bus_data               (in_bus_data),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_irq_out               (out_irq_out),
    .out_mirror_horizontal_out (out_mirror_horizontal_out),
    .out_prg_bank_first        (out_prg_bank_first),
    .out_prg_bank_second       (out_prg_bank_second),
    .out_prg_bank_third        (out_prg_bank_third),
    .out_chr_write_valid       (out_chr_write_valid),
    .out_chr_slot              (out_chr_slot),
    .out_chr_bank              (out_chr_bank),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .pready                    (pready),
    .outstanding               (outstanding),
    .mismatches                (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure: redraw the stall every cycle, independent of out_valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one beat after a random gap, then hold it steady until it is taken.
  // Valid is only ever lowered by a gap or by a drain, never just after a
  // beat, so a back-to-back beat sees a single assignment per edge.
  task automatic send_beat(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= c;
    in_bus_address <= a;
    in_bus_data    <= d;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_write(input logic [15:0] a, input logic [7:0] d);
    send_beat(CMD_WRITE, a, d);
  endtask

  // Address and data are ignored on a tick, so fill them with noise
  task automatic send_tick();
    send_beat(CMD_TICK, 16'($urandom), 8'($urandom));
  endtask

  // Control register address with random don't-care bits between region and code
  function automatic logic [15:0] ctrl_addr(input logic [2:0] code);
    return {REGION_CTRL, 9'($urandom), code};
  endfunction

  // Drop valid and hold until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One APB setup and access phase; psel stays high so writes can chain
  task automatic apb_write(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write both bank limits back to back, then release the bus
  task automatic write_limits(input logic [7:0] prg_max, input logic [7:0] chr_max);
    apb_write(REG_PRG_MAX, prg_max);
    apb_write(REG_CHR_MAX, chr_max);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A single random beat: ticks, bank writes, control writes and raw noise
  task automatic send_random_item();
    int unsigned k;
    logic [3:0]  region;
    logic [2:0]  code;
    k = $urandom_range(99);
    if (k < 30) begin
      send_tick();
    end else if (k < 45) begin
      case ($urandom_range(2))
        0:       region = REGION_PRG0;
        1:       region = REGION_PRG1;
        default: region = REGION_PRG2;
      endcase
      send_write({region, 12'($urandom)}, 8'($urandom));
    end else if (k < 60) begin
      send_write({REGION_CHR, 12'($urandom)}, 8'($urandom));
    end else if (k < 80) begin
      case ($urandom_range(4))
        0:       code = CTRL_MIRROR;
        1:       code = CTRL_ENABLE;
        2:       code = CTRL_RELOAD;
        3:       code = CTRL_LOAD_HI;
        default: code = CTRL_LOAD_LO;
      endcase
      send_write(ctrl_addr(code), 8'($urandom));
    end else if (k < 90) begin
      // any low code, the unused ones included
      send_write(ctrl_addr(3'($urandom)), 8'($urandom));
    end else begin
      send_beat(cmd_t'($urandom_range(1)), 16'($urandom), 8'($urandom));
    end
  endtask

  // Program a mostly short count, load it, enable it and tick it down to zero or
  // past it so the interrupt can fire. Each set-up step is now and then skipped
  // to break the sequence, and stray beats land among the ticks.
  task automatic send_counter_run();
    logic [7:0]  hi;
    logic [7:0]  lo;
    int unsigned ticks;
    hi = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
    lo = 8'($urandom_range(24));
    if ($urandom_range(9) != 0) send_write(ctrl_addr(CTRL_LOAD_HI), hi);
    if ($urandom_range(9) != 0) send_write(ctrl_addr(CTRL_LOAD_LO), lo);
    if ($urandom_range(9) != 0) send_write(ctrl_addr(CTRL_RELOAD), 8'($urandom));
    send_write(ctrl_addr(CTRL_ENABLE), {1'($urandom_range(9) != 0), 7'($urandom)});
    ticks = lo + $urandom_range(4);
    repeat (ticks) begin
      if ($urandom_range(9) == 0) send_random_item();
      send_tick();
    end
  endtask

  initial begin
    int unsigned target;

    // Hold reset at the start, then release it once for the whole run
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the first idling phase, limits still at reset
    send_idle_pct = 36;
    recv_idle_pct = 70;
    send_write({REGION_PRG0, 12'h000}, 8'hFF);
    send_write({REGION_PRG1, 12'hFFF}, 8'h00);
    send_write({REGION_PRG2, 12'h5A5}, 8'h80);
    send_write({REGION_CHR, 12'h000}, 8'hFF);
    send_write({REGION_CHR, 12'hFFF}, 8'h5A);
    send_write({REGION_CTRL, 9'h000, CTRL_MIRROR}, 8'h80);
    send_write({REGION_CTRL, 9'h1FF, CTRL_MIRROR}, 8'h7F);
    // Count of two: two ticks reach zero, the third raises the line
    send_write({REGION_CTRL, 9'h000, CTRL_LOAD_HI}, 8'h00);
    send_write({REGION_CTRL, 9'h000, CTRL_LOAD_LO}, 8'h02);
    send_write({REGION_CTRL, 9'h000, CTRL_RELOAD}, 8'h00);
    send_write({REGION_CTRL, 9'h000, CTRL_ENABLE}, 8'h80);
    send_tick();
    send_tick();
    // Clear the line while the delay is armed: it must still rise on the tick
    send_write({REGION_CTRL, 9'h000, CTRL_ENABLE}, 8'h00);
    send_tick();
    send_write({REGION_CTRL, 9'h000, CTRL_RELOAD}, 8'hFF);
    // Addresses that touch nothing
    send_write(16'h0000, 8'hFF);
    send_write(16'h7FFF, 8'hFF);
    send_write(16'hD123, 8'hFF);
    send_write(16'hFFFF, 8'h00);
    send_write({REGION_CTRL, 12'h000}, 8'hFF);
    send_write({REGION_CTRL, 12'h002}, 8'hFF);
    send_write({REGION_CTRL, 12'hFFF}, 8'hFF);

    // Narrow limits so that banks above them are masked
    wait_drained();
    write_limits(8'h05, 8'h13);
    send_write({REGION_PRG0, 12'h000}, 8'h07);
    send_write({REGION_PRG1, 12'h000}, 8'h05);
    send_write({REGION_CHR, 12'h003}, 8'hFF);

    // Random segments: each phase of idling spans two segments, limits change
    // at every segment boundary and the sender waits for a full drain halfway
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_drained();
      case (s / 2)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (s)
        0:       write_limits(8'h00, 8'h00);
        1:       write_limits(8'hFF, 8'hFF);
        2:       write_limits(8'hFF, 8'h00);
        3:       write_limits(8'h00, 8'hFF);
        default: write_limits(8'($urandom), 8'($urandom));
      endcase
      target = beats_sent;
      repeat (2) begin
        target += HALF_SEGMENT;
        while (beats_sent < target) begin
          if ($urandom_range(2) == 0) send_counter_run();
          else                        send_random_item();
        end
        wait_drained();
      end
    end

    // Let any stray result surface before the verdict
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run
  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
